FILE: hdl/chrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrl_pkg: shared types and constants for the hash ring lookup
// Field widths, item kinds, hash constants and the lookup result record.
// ----------------------------------------------------------------------------
package chrl_pkg;

  localparam int unsigned IndexWidth    = 5;
  localparam int unsigned PositionWidth = 32;
  localparam int unsigned StorageWidth  = 2;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned UsedWidth     = 6;

  localparam logic [PositionWidth-1:0] HashSeed  = 32'd5381;
  localparam int unsigned              HashShift = 5;
  localparam logic [UsedWidth-1:0]     UsedReset = 6'd30;

  // item kind carried in tuser
  localparam logic OpLoad = 1'b0;
  localparam logic OpKey  = 1'b1;

  typedef struct packed {
    logic [PositionWidth-1:0] hash;
    logic [StorageWidth-1:0]  owner;
  } result_t;

endpackage

FILE: hdl/consistent_hash_ring_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consistent_hash_ring_lookup: route keys to storage nodes on a hash ring
//
// Input stream: tuser selects the item kind. A load transfer (tuser = 0)
// writes one ring entry (position, storage) at entry_index; software loads
// entries in ascending position order. A key transfer (tuser = 1) carries one
// key byte, folded into a djb2 hash; tlast marks the key's final byte.
// Load and non-final key transfers are accepted while the ring is idle. After
// the final key byte the input stalls while one comparator walks the ring
// entries, one per cycle from a registered memory read, until the matching
// entry is found or, after ring_entries_used entries capped at the ring depth,
// the search wraps to entry 0; the result then sits in the output register.
// The output register lets load and key bytes of the next key flow while a
// result waits; a stalled receiver only holds the next search at its end.
// cfg_wr_en_i writes ring_entries_used; do so only while idle.
// Reset: ring_entries_used = 30, hash seed reloaded, output empty. Ring
// entries are not cleared and must be loaded before they are searched.
// ----------------------------------------------------------------------------
module consistent_hash_ring_lookup
  import chrl_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [5:0]  cfg_wr_data_i,  // ring_entries_used
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] entry_index, [36:5] entry_position, [38:37] entry_storage,
  // [46:39] key_byte, [47] zero
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // op
  input  logic        s_axis_tlast,   // key_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] storage_index, [33:2] key_hash, [39:34] zero
  output logic [39:0] m_axis_tdata
);

  logic [UsedWidth-1:0]     used_q;
  logic                     in_xfer;
  logic                     key_en;
  logic [PositionWidth-1:0] key_hash;
  logic                     ring_idle;
  logic                     res_vld;
  result_t                  res;
  logic                     res_rdy;
  logic                     out_vld_q;
  result_t                  out_q;

  assign s_axis_tready = ring_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign key_en        = in_xfer && (s_axis_tuser == OpKey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= UsedReset;
    end else if (cfg_wr_en_i) begin
      used_q <= cfg_wr_data_i;
    end
  end

  chrl_hash u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_en_i (key_en),
    .byte_i    (s_axis_tdata[46:39]),
    .last_i    (s_axis_tlast),
    .hash_o    (key_hash)
  );

  chrl_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_en_i       (in_xfer && (s_axis_tuser == OpLoad)),
    .wr_index_i    (s_axis_tdata[4:0]),
    .wr_position_i (s_axis_tdata[36:5]),
    .wr_storage_i  (s_axis_tdata[38:37]),
    .start_i       (key_en && s_axis_tlast),
    .hash_i        (key_hash),
    .used_i        (used_q),
    .idle_o        (ring_idle),
    .res_vld_o     (res_vld),
    .res_o         (res),
    .res_rdy_i     (res_rdy)
  );

  assign res_rdy = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (res_rdy) begin
      out_vld_q <= res_vld;
      if (res_vld) begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_q.hash, out_q.owner};

endmodule

FILE: hdl/chrl_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrl_hash: djb2 key hash accumulator
// Folds one signed key byte per transfer; a zero byte freezes the hash until
// the last byte, which returns the accumulator to the seed.
// ----------------------------------------------------------------------------
module chrl_hash
  import chrl_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     byte_en_i,
  input  logic [ByteWidth-1:0]     byte_i,
  input  logic                     last_i,
  output logic [PositionWidth-1:0] hash_o
);

  logic [PositionWidth-1:0] hash_q, hash_d;
  logic                     term_q, term_d;
  logic [PositionWidth-1:0] byte_ext;
  logic                     fold;

  assign byte_ext = {{(PositionWidth-ByteWidth){byte_i[ByteWidth-1]}}, byte_i};
  assign fold     = byte_en_i && !term_q && (byte_i != '0);

  // hash * 33 + byte, wraps mod 2^32
  assign hash_o = fold ? ((hash_q << HashShift) + hash_q + byte_ext) : hash_q;

  always_comb begin
    hash_d = hash_q;
    term_d = term_q;
    if (byte_en_i) begin
      if (last_i) begin
        hash_d = HashSeed;
        term_d = 1'b0;
      end else begin
        hash_d = hash_o;
        if (byte_i == '0) begin
          term_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashSeed;
      term_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      term_q <= term_d;
    end
  end

endmodule

FILE: hdl/chrl_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chrl_ring: ring entry memory and sequential search
// One comparator walks the entries one per cycle behind a registered read
// port; the first position >= hash wins, otherwise entry 0 is reported.
// ----------------------------------------------------------------------------
module chrl_ring
  import chrl_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [IndexWidth-1:0]    wr_index_i,
  input  logic [PositionWidth-1:0] wr_position_i,
  input  logic [StorageWidth-1:0]  wr_storage_i,
  input  logic                     start_i,
  input  logic [PositionWidth-1:0] hash_i,
  input  logic [UsedWidth-1:0]     used_i,
  output logic                     idle_o,
  output logic                     res_vld_o,
  output result_t                  res_o,
  input  logic                     res_rdy_i
);

  localparam int unsigned AddrWidth  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CountWidth = $clog2(RING_DEPTH + 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  logic [PositionWidth-1:0] pos_mem [RING_DEPTH];
  logic [StorageWidth-1:0]  own_mem [RING_DEPTH];

  state_e                   state_q;
  logic [CountWidth-1:0]    idx_q;
  logic [CountWidth-1:0]    cnt_q;
  logic [PositionWidth-1:0] hash_q;
  logic                     pend_q;
  logic                     wrap_q;
  logic                     wrap_sent_q;
  logic [StorageWidth-1:0]  res_own_q;
  logic [PositionWidth-1:0] rd_pos_q;
  logic [StorageWidth-1:0]  rd_own_q;

  logic [CountWidth-1:0]    cnt_start;
  logic                     wr_in_range;
  logic [AddrWidth-1:0]     rd_addr;
  logic                     hit;
  logic                     issue_entry;
  logic                     issue_wrap;

  // entries searched saturate at the ring depth
  assign cnt_start = (32'(used_i) > RING_DEPTH) ? CountWidth'(RING_DEPTH)
                                                : CountWidth'(used_i);
  assign wr_in_range = 32'(wr_index_i) < RING_DEPTH;

  assign hit         = pend_q && (wrap_q || (rd_pos_q >= hash_q));
  assign issue_entry = idx_q < cnt_q;
  assign issue_wrap  = !issue_entry && !wrap_sent_q;
  assign rd_addr     = issue_entry ? idx_q[AddrWidth-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_in_range) begin
      pos_mem[AddrWidth'(wr_index_i)] <= wr_position_i;
      own_mem[AddrWidth'(wr_index_i)] <= wr_storage_i;
    end
    rd_pos_q <= pos_mem[rd_addr];
    rd_own_q <= own_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= '0;
      hash_q      <= '0;
      pend_q      <= 1'b0;
      wrap_q      <= 1'b0;
      wrap_sent_q <= 1'b0;
      res_own_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (start_i) begin
            hash_q      <= hash_i;
            cnt_q       <= cnt_start;
            idx_q       <= '0;
            pend_q      <= 1'b0;
            wrap_q      <= 1'b0;
            wrap_sent_q <= 1'b0;
            state_q     <= StScan;
          end
        end
        StScan: begin
          if (hit) begin
            res_own_q <= rd_own_q;
            pend_q    <= 1'b0;
            state_q   <= StDone;
          end else begin
            // wrap read goes out once, right behind the last entry
            pend_q <= issue_entry || issue_wrap;
            wrap_q <= issue_wrap;
            if (issue_entry) begin
              idx_q <= idx_q + 1'b1;
            end
            if (issue_wrap) begin
              wrap_sent_q <= 1'b1;
            end
          end
        end
        StDone: begin
          if (res_rdy_i) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign res_vld_o   = (state_q == StDone);
  assign res_o.hash  = hash_q;
  assign res_o.owner = res_own_q;

endmodule
